>>> src/pqs_pkg.sv
package pqs_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned PER_W  = 16;
  localparam int unsigned DUE_W  = 48;
  localparam int unsigned STAT_W = 2;

  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
  localparam logic [OP_W-1:0] OP_DISPATCH = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  localparam logic [DUE_W-1:0] DUE_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_LAST,
    ST_UPDATE,
    ST_POST
  } state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic add;
    logic full_res;
    logic empty_res;
    logic scan_init;
    logic scan_issue;
    logic update;
    logic post;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            scan_last;
    logic            out_free;
  } stat_t;

  typedef struct packed {
    logic [DUE_W-1:0] due;
    logic [ID_W-1:0]  id;
    logic [PER_W-1:0] per;
  } entry_t;

endpackage

>>> src/pqs_if.sv
interface pqs_req_if;
  logic                       valid;
  logic                       ready;
  logic [pqs_pkg::OP_W-1:0]  operation;
  logic [pqs_pkg::ID_W-1:0]  entry_id;
  logic [pqs_pkg::PER_W-1:0] period;

  modport source (output valid, output operation, output entry_id, output period,
                  input ready);
  modport sink   (input valid, input operation, input entry_id, input period,
                  output ready);
endinterface

interface pqs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pqs_pkg::ID_W-1:0]   served_id;
  logic [pqs_pkg::STAT_W-1:0] status;
  logic                        overflow;

  modport source (output valid, output served_id, output status, output overflow,
                  input ready);
  modport sink   (input valid, input served_id, input status, input overflow,
                  output ready);
endinterface

>>> src/pqs_controller.sv
module pqs_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pqs_pkg::stat_t stat_i,
  output pqs_pkg::cmd_t  cmd_o
);

  pqs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pqs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pqs_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = pqs_pkg::ST_DECODE;
      end
      pqs_pkg::ST_DECODE: begin
        unique case (stat_i.op)
          pqs_pkg::OP_ADD:      state_d = pqs_pkg::ST_POST;
          pqs_pkg::OP_DISPATCH: state_d = stat_i.empty ? pqs_pkg::ST_POST
                                                       : pqs_pkg::ST_SCAN;
          default:              state_d = pqs_pkg::ST_IDLE;
        endcase
      end
      pqs_pkg::ST_SCAN: begin
        if (stat_i.scan_last) state_d = pqs_pkg::ST_LAST;
      end
      pqs_pkg::ST_LAST:   state_d = pqs_pkg::ST_UPDATE;
      pqs_pkg::ST_UPDATE: state_d = pqs_pkg::ST_POST;
      pqs_pkg::ST_POST: begin
        if (stat_i.out_free) state_d = pqs_pkg::ST_IDLE;
      end
      default: state_d = pqs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      pqs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      pqs_pkg::ST_DECODE: begin
        unique case (stat_i.op)
          pqs_pkg::OP_CLEAR: cmd_o.clear = 1'b1;
          pqs_pkg::OP_ADD: begin
            cmd_o.full_res = stat_i.full;
            cmd_o.add      = !stat_i.full;
          end
          pqs_pkg::OP_DISPATCH: begin
            cmd_o.empty_res = stat_i.empty;
            cmd_o.scan_init = !stat_i.empty;
          end
          default: ;
        endcase
      end
      pqs_pkg::ST_SCAN:   cmd_o.scan_issue = 1'b1;
      pqs_pkg::ST_LAST:   ;
      pqs_pkg::ST_UPDATE: cmd_o.update = 1'b1;
      pqs_pkg::ST_POST:   cmd_o.post = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

>>> src/pqs_datapath.sv
module pqs_datapath #(
  parameter int unsigned MAX_ENTRIES = pqs_pkg::MAX_ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pqs_pkg::cmd_t               cmd_i,
  output pqs_pkg::stat_t              stat_o,
  input  logic [pqs_pkg::OP_W-1:0]    operation_i,
  input  logic [pqs_pkg::ID_W-1:0]    entry_id_i,
  input  logic [pqs_pkg::PER_W-1:0]   period_i,
  input  logic                        rsp_ready_i,
  output logic                        rsp_valid_o,
  output logic [pqs_pkg::ID_W-1:0]    served_id_o,
  output logic [pqs_pkg::STAT_W-1:0]  status_o,
  output logic                        overflow_o
);

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  logic [pqs_pkg::OP_W-1:0]  op_q;
  logic [pqs_pkg::ID_W-1:0]  id_q;
  logic [pqs_pkg::PER_W-1:0] per_q;

  logic [CW-1:0] count_q;
  logic [IW-1:0] idx_q;

  pqs_pkg::entry_t mem [MAX_ENTRIES];
  pqs_pkg::entry_t rd_q;
  logic [IW-1:0]   rd_idx_q;
  logic            rd_vld_q;

  pqs_pkg::entry_t best_q;
  logic [IW-1:0]   best_idx_q;
  logic            take;

  logic                     mem_we;
  logic [IW-1:0]            mem_wa;
  pqs_pkg::entry_t          mem_wd;
  logic [pqs_pkg::DUE_W:0]   sum;
  logic                     sat;
  logic [pqs_pkg::DUE_W-1:0] next_due;

  logic [pqs_pkg::ID_W-1:0]   pend_id_q;
  logic [pqs_pkg::STAT_W-1:0] pend_stat_q;
  logic                       pend_ovf_q;

  logic                       rsp_valid_q;
  logic [pqs_pkg::ID_W-1:0]   rsp_id_q;
  logic [pqs_pkg::STAT_W-1:0] rsp_stat_q;
  logic                       rsp_ovf_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      id_q  <= entry_id_i;
      per_q <= period_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
    end else if (cmd_i.add) begin
      count_q <= count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      idx_q <= '0;
    end else if (cmd_i.scan_issue) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  // due + period, saturating at the top of the 48-bit range
  assign sum      = {1'b0, best_q.due} + (pqs_pkg::DUE_W + 1)'(best_q.per);
  assign sat      = sum[pqs_pkg::DUE_W];
  assign next_due = sat ? pqs_pkg::DUE_MAX : sum[pqs_pkg::DUE_W-1:0];

  always_comb begin
    mem_we = cmd_i.add || cmd_i.update;
    if (cmd_i.add) begin
      mem_wa = count_q[IW-1:0];
      mem_wd = '{due: pqs_pkg::DUE_W'(per_q), id: id_q, per: per_q};
    end else begin
      mem_wa = best_idx_q;
      mem_wd = '{due: next_due, id: best_q.id, per: best_q.per};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd_i.scan_issue) begin
      rd_q     <= mem[idx_q];
      rd_idx_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_issue;
    end
  end

  // strict compare: on a full tie the lower slot, added earlier, stays
  assign take = (rd_idx_q == '0) || (rd_q.due < best_q.due) ||
                ((rd_q.due == best_q.due) && (rd_q.id < best_q.id));

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && take) begin
      best_q     <= rd_q;
      best_idx_q <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      pend_id_q   <= '0;
      pend_stat_q <= pqs_pkg::STAT_OK;
      pend_ovf_q  <= 1'b0;
    end else if (cmd_i.full_res) begin
      pend_id_q   <= '0;
      pend_stat_q <= pqs_pkg::STAT_FULL;
      pend_ovf_q  <= 1'b0;
    end else if (cmd_i.empty_res) begin
      pend_id_q   <= '0;
      pend_stat_q <= pqs_pkg::STAT_EMPTY;
      pend_ovf_q  <= 1'b0;
    end else if (cmd_i.update) begin
      pend_id_q   <= best_q.id;
      pend_stat_q <= pqs_pkg::STAT_OK;
      pend_ovf_q  <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.post) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post) begin
      rsp_id_q   <= pend_id_q;
      rsp_stat_q <= pend_stat_q;
      rsp_ovf_q  <= pend_ovf_q;
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.full      = (count_q == CW'(MAX_ENTRIES));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.scan_last = (idx_q == IW'(count_q - CW'(1)));
  assign stat_o.out_free  = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o = rsp_valid_q;
  assign served_id_o = rsp_id_q;
  assign status_o    = rsp_stat_q;
  assign overflow_o  = rsp_ovf_q;

endmodule

>>> src/periodic_query_scheduler.sv
// Periodic scheduler over a store of up to MAX_ENTRIES entries (identifier, period,
// 48-bit due time) held in an entry memory. One word is taken at a time: a clear or
// an unused operation code gives no result, and an add gives one; a dispatch runs a
// linear scan that reads the entry memory one entry per cycle to find the earliest
// due time (smaller identifier, then older entry, on a tie); a dispatch on an empty
// store skips the scan. A result sits in an output register, so the next word is
// taken while it waits; a result is only held back if the previous one is still
// not taken.
module periodic_query_scheduler #(
  parameter int unsigned MAX_ENTRIES = pqs_pkg::MAX_ENTRIES_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  pqs_req_if.sink   req_i,
  pqs_rsp_if.source rsp_o
);

  pqs_pkg::cmd_t  cmd;
  pqs_pkg::stat_t stat;

  logic                       in_valid;
  logic                       in_ready;
  logic [pqs_pkg::OP_W-1:0]   operation;
  logic [pqs_pkg::ID_W-1:0]   entry_id;
  logic [pqs_pkg::PER_W-1:0]  period;
  logic                       rsp_valid;
  logic                       rsp_ready;
  logic [pqs_pkg::ID_W-1:0]   served_id;
  logic [pqs_pkg::STAT_W-1:0] status;
  logic                       overflow;

  assign in_valid  = req_i.valid;
  assign operation = req_i.operation;
  assign entry_id  = req_i.entry_id;
  assign period    = req_i.period;
  assign req_i.ready = in_ready;

  assign rsp_ready       = rsp_o.ready;
  assign rsp_o.valid     = rsp_valid;
  assign rsp_o.served_id = served_id;
  assign rsp_o.status    = status;
  assign rsp_o.overflow  = overflow;

  pqs_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pqs_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .operation_i (operation),
    .entry_id_i  (entry_id),
    .period_i    (period),
    .rsp_ready_i (rsp_ready),
    .rsp_valid_o (rsp_valid),
    .served_id_o (served_id),
    .status_o    (status),
    .overflow_o  (overflow)
  );

endmodule

>>> src/pqs_checker.sv
module pqs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [pqs_pkg::ID_W-1:0]   served_id_i,
  input logic [pqs_pkg::STAT_W-1:0] status_i,
  input logic                       overflow_i
);

  a_fail_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != pqs_pkg::STAT_OK) |-> (served_id_i == '0))
    else $error("non-ok word carries an identifier");

  a_ovf_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && overflow_i |-> (status_i == pqs_pkg::STAT_OK))
    else $error("overflow flagged on a non-ok word");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("word taken while the previous one is in progress");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(served_id_i) && $stable(status_i) && $stable(overflow_i))
    else $error("stalled result word changed");

endmodule

bind periodic_query_scheduler pqs_checker u_pqs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid),
  .in_ready_i  (in_ready),
  .rsp_valid_i (rsp_valid),
  .rsp_ready_i (rsp_ready),
  .served_id_i (served_id),
  .status_i    (status),
  .overflow_i  (overflow)
);
